// ===== sv/assert_macros.svh =====
// Assertion macros shared by the solver RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/tsat_pkg.sv =====
// Package: types and constants of the 2-SAT SCC solver
package tsat_pkg;
   localparam int DEF_MAX_VARS  = 32;
   localparam int DEF_MAX_EDGES = 256;
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_SOLVE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;
   typedef enum logic [4:0] {
      S_IDLE, S_RESP, S_P1_ROOT, S_P1_TOP, S_P1_SCAN, S_P1_EDGE, S_P1_POP,
      S_P2_ROOT, S_P2_FIN, S_P2_TOP, S_P2_SCAN, S_P2_EDGE, S_P2_POP,
      S_OUT_A, S_OUT_B, S_OUT_C, S_CHK_A, S_CHK_B, S_CHK_C
   } state_type;
endpackage

// ===== sv/two_sat_scc_solver_top.sv =====
// Top level: 2-SAT solver, Kosaraju SCC over an edge memory
// Add and clear: result in the cycle after acceptance; a new item each cycle when rsp drains.
// Solve: two DFS passes, each scanning the edge memory serially for the vertices it visits,
// then a check pass and an output pass over the variables.
// One item is worked at a time during a solve; the input stalls until the last result is out.
// Reset: synchronous, edge count 0, num_vars 32; memory contents undefined.
module two_sat_scc_solver_top
   import tsat_pkg::*;
#(
   parameter int MAX_VARS  = DEF_MAX_VARS,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [5:0] req_from_vertex,
   input  logic [5:0] req_to_vertex,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_variable,
   output logic       rsp_value,
   output logic       rsp_satisfiable,
   output logic [6:0] rsp_components,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_num_vars
);
`include "assert_macros.svh"
   localparam int NV = 2 * MAX_VARS;
   localparam int VW = (NV > 1) ? $clog2(NV) : 1;
   localparam int EW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int KW = $clog2(NV + 1);

   state_type state_ff, state_in;
   logic [5:0]    nvars_ff;
   logic [CW-1:0] ecount_ff, ecount_in;
   logic [NV-1:0] visited_ff, visited_in;
   logic [KW-1:0] sp_ff, sp_in, nfin_ff, nfin_in, fidx_ff, fidx_in;
   logic [VW-1:0] root_ff, root_in, vtx_ff, vtx_in, bvtx_ff, bvtx_in;
   logic [CW-1:0] epos_ff, epos_in;
   logic [6:0]    comps_ff, comps_in;
   logic [5:0]    var_ff, var_in;
   logic [5:0]    ctrue_ff, ctrue_in;
   logic          sat_ff, sat_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rst_ff, rst_in;
   logic [4:0]    rvar_ff, rvar_in;
   logic          rval_ff, rval_in, rsat_ff, rsat_in, rlast_ff, rlast_in;
   logic [6:0]    rcomp_ff, rcomp_in;

   logic [5:0] n6;
   logic [6:0] nv7;
   always_comb begin
      if (nvars_ff == 6'd0) n6 = 6'd1;
      else if ({26'd0, nvars_ff} > 32'(MAX_VARS)) n6 = 6'(MAX_VARS);
      else n6 = nvars_ff;
      nv7 = {n6, 1'b0};
   end

   // memories
   logic          e_we;
   logic [EW-1:0] e_wa, e_ra;
   logic [11:0]   e_wd, e_rd;
   logic          s_we;  logic [VW-1:0] s_wa, s_ra; logic [VW+CW-1:0] s_wd, s_rd;
   logic          f_we;  logic [VW-1:0] f_wa, f_ra; logic [VW-1:0] f_wd, f_rd;
   logic          c_we;  logic [VW-1:0] c_wa, c_ra; logic [5:0] c_wd, c_rd;

   tsat_ram #(.WIDTH(12), .DEPTH(MAX_EDGES)) u_edge (.clock, .wr_en(e_we), .wr_addr(e_wa),
      .wr_data(e_wd), .rd_addr(e_ra), .rd_data(e_rd));
   tsat_ram #(.WIDTH(VW+CW), .DEPTH(NV)) u_stack (.clock, .wr_en(s_we), .wr_addr(s_wa),
      .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));
   tsat_ram #(.WIDTH(VW), .DEPTH(NV)) u_fin (.clock, .wr_en(f_we), .wr_addr(f_wa),
      .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));
   tsat_ram #(.WIDTH(6), .DEPTH(NV)) u_comp (.clock, .wr_en(c_we), .wr_addr(c_wa),
      .wr_data(c_wd), .rd_addr(c_ra), .rd_data(c_rd));

   logic out_free, acc;
   assign out_free  = !rv_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign acc       = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   logic [5:0] ea, eb;
   logic [VW-1:0] top_v;
   logic [CW-1:0] top_e;
   assign top_v = s_rd[VW+CW-1:CW];
   assign top_e = s_rd[CW-1:0];

   always_comb begin
      state_in = state_ff; ecount_in = ecount_ff; visited_in = visited_ff;
      sp_in = sp_ff; nfin_in = nfin_ff; fidx_in = fidx_ff; root_in = root_ff;
      vtx_in = vtx_ff; bvtx_in = bvtx_ff; epos_in = epos_ff; comps_in = comps_ff;
      var_in = var_ff; ctrue_in = ctrue_ff; sat_in = sat_ff;
      rv_in = rv_ff && rsp_stall; rst_in = rst_ff; rvar_in = rvar_ff; rval_in = rval_ff;
      rsat_in = rsat_ff; rcomp_in = rcomp_ff; rlast_in = rlast_ff;
      e_we = 1'b0; e_wa = ecount_ff[EW-1:0]; e_wd = {req_from_vertex, req_to_vertex};
      e_ra = epos_ff[EW-1:0];
      s_we = 1'b0; s_wa = sp_ff[VW-1:0]; s_wd = {vtx_ff, epos_ff}; s_ra = VW'(sp_ff - 1'b1);
      f_we = 1'b0; f_wa = nfin_ff[VW-1:0]; f_wd = vtx_ff; f_ra = VW'(fidx_ff - 1'b1);
      c_we = 1'b0; c_wa = vtx_ff; c_wd = comps_ff[5:0]; c_ra = var_ff[VW-1:0];
      ea = e_rd[11:6]; eb = e_rd[5:0];
      if (state_ff >= S_P2_ROOT && state_ff <= S_P2_POP) begin
         ea = e_rd[5:0]; eb = e_rd[11:6];
      end
      unique case (state_ff)
         S_IDLE: if (acc) begin
            unique case (req_command)
               CMD_ADD: begin
                  rv_in = 1'b1; rvar_in = '0; rval_in = 1'b0; rsat_in = 1'b0; rcomp_in = '0;
                  rlast_in = 1'b1;
                  if ({1'b0, req_from_vertex} >= nv7 || {1'b0, req_to_vertex} >= nv7)
                     rst_in = ST_RANGE;
                  else if (ecount_ff >= CW'(MAX_EDGES)) rst_in = ST_FULL;
                  else begin
                     rst_in = ST_OK; e_we = 1'b1; ecount_in = ecount_ff + 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  rv_in = 1'b1; rst_in = ST_OK; rvar_in = '0; rval_in = 1'b0; rsat_in = 1'b0;
                  rcomp_in = '0; rlast_in = 1'b1; ecount_in = '0;
               end
               CMD_SOLVE: begin
                  visited_in = '0; nfin_in = '0; root_in = '0; state_in = S_P1_ROOT;
               end
               default: ;
            endcase
         end
         S_P1_ROOT: begin
            if (7'(root_ff) >= nv7) begin
               visited_in = '0; fidx_in = nfin_ff; comps_in = '0; state_in = S_P2_ROOT;
            end else if (visited_ff[root_ff]) begin
               root_in = root_ff + 1'b1;
               if (32'(root_ff) == NV - 1) begin
                  visited_in = '0; fidx_in = nfin_ff; comps_in = '0; state_in = S_P2_ROOT;
               end
            end else begin
               visited_in[root_ff] = 1'b1; vtx_in = root_ff; epos_in = '0;
               s_we = 1'b1; s_wa = '0; s_wd = {root_ff, {CW{1'b0}}}; sp_in = KW'(1);
               state_in = S_P1_TOP;
            end
         end
         S_P1_TOP, S_P2_TOP: begin
            if (sp_ff == '0) begin
               if (state_ff == S_P1_TOP) begin
                  root_in = root_ff + 1'b1;
                  if (32'(root_ff) == NV - 1) begin
                     visited_in = '0; fidx_in = nfin_ff; comps_in = '0; state_in = S_P2_ROOT;
                  end else state_in = S_P1_ROOT;
               end else begin
                  comps_in = comps_ff + 1'b1; state_in = S_P2_ROOT;
               end
            end else state_in = (state_ff == S_P1_TOP) ? S_P1_SCAN : S_P2_SCAN;
         end
         S_P1_SCAN, S_P2_SCAN: begin
            vtx_in = top_v; epos_in = top_e; e_ra = top_e[EW-1:0];
            if (top_e >= ecount_ff)
               state_in = (state_ff == S_P1_SCAN) ? S_P1_POP : S_P2_POP;
            else state_in = (state_ff == S_P1_SCAN) ? S_P1_EDGE : S_P2_EDGE;
         end
         S_P1_EDGE, S_P2_EDGE: begin
            epos_in = epos_ff + 1'b1; e_ra = EW'(epos_ff + 1'b1);
            if (ea == 6'(vtx_ff) && {1'b0, ea} < nv7 && {1'b0, eb} < nv7
                && !visited_ff[eb[VW-1:0]]) begin
               visited_in[eb[VW-1:0]] = 1'b1;
               s_we = 1'b1; s_wa = VW'(sp_ff - 1'b1); s_wd = {vtx_ff, CW'(epos_ff + 1'b1)};
               bvtx_in = eb[VW-1:0];
               state_in = (state_ff == S_P1_EDGE) ? S_P1_POP : S_P2_POP;
               // push of bvtx handled in POP stage, flagged by epos all ones
               epos_in = '1;
            end else if (epos_ff + 1'b1 >= ecount_ff) begin
               epos_in = epos_ff + 1'b1;
               state_in = (state_ff == S_P1_EDGE) ? S_P1_POP : S_P2_POP;
            end
         end
         S_P1_POP, S_P2_POP: begin
            if (epos_ff == '1) begin
               if (state_ff == S_P2_POP) begin
                  c_we = 1'b1; c_wa = bvtx_ff;
               end
               if (32'(sp_ff) < NV) begin
                  s_we = 1'b1; s_wa = sp_ff[VW-1:0]; s_wd = {bvtx_ff, {CW{1'b0}}};
                  sp_in = sp_ff + 1'b1;
               end
            end else begin
               sp_in = sp_ff - 1'b1;
               if (state_ff == S_P1_POP && 32'(nfin_ff) < NV) begin
                  f_we = 1'b1; nfin_in = nfin_ff + 1'b1;
               end
            end
            state_in = (state_ff == S_P1_POP) ? S_P1_TOP : S_P2_TOP;
         end
         S_P2_ROOT: begin
            if (fidx_ff == '0) begin
               var_in = '0; sat_in = 1'b1; state_in = S_CHK_A;
            end else state_in = S_P2_FIN;
         end
         S_P2_FIN: begin
            fidx_in = fidx_ff - 1'b1;
            if ({1'b0, 6'(f_rd)} < nv7 && !visited_ff[f_rd]) begin
               visited_in[f_rd] = 1'b1; vtx_in = f_rd; c_we = 1'b1; c_wa = f_rd;
               s_we = 1'b1; s_wa = '0; s_wd = {f_rd, {CW{1'b0}}}; sp_in = KW'(1);
               state_in = S_P2_TOP;
            end else state_in = S_P2_ROOT;
         end
         S_CHK_A: begin
            c_ra = var_ff[VW-1:0]; state_in = S_CHK_B;
         end
         S_CHK_B: begin
            ctrue_in = c_rd; c_ra = VW'(var_ff + n6); state_in = S_CHK_C;
         end
         S_CHK_C: begin
            if (ctrue_ff == c_rd) sat_in = 1'b0;
            if (var_ff + 1'b1 >= n6) begin
               var_in = '0; state_in = S_OUT_A;
            end else begin
               var_in = var_ff + 1'b1; state_in = S_CHK_A;
            end
         end
         S_OUT_A: begin
            c_ra = var_ff[VW-1:0]; state_in = S_OUT_B;
         end
         S_OUT_B: begin
            ctrue_in = c_rd; c_ra = VW'(var_ff + n6); state_in = S_OUT_C;
         end
         S_OUT_C: begin
            c_ra = VW'(var_ff + n6);
            if (out_free) begin
               rv_in = 1'b1; rst_in = ST_OK; rvar_in = var_ff[4:0];
               rval_in = ctrue_ff > c_rd; rsat_in = sat_ff; rcomp_in = comps_ff;
               rlast_in = (var_ff + 1'b1 == n6);
               if (var_ff + 1'b1 == n6) state_in = S_IDLE;
               else begin
                  var_in = var_ff + 1'b1; state_in = S_OUT_A;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; nvars_ff <= 6'd32; ecount_ff <= '0; rv_ff <= 1'b0;
         visited_ff <= '0;
      end else begin
         state_ff <= state_in; ecount_ff <= ecount_in; rv_ff <= rv_in;
         visited_ff <= visited_in;
         if (csr_valid) nvars_ff <= csr_num_vars;
      end
      sp_ff <= sp_in; nfin_ff <= nfin_in; fidx_ff <= fidx_in; root_ff <= root_in;
      vtx_ff <= vtx_in; bvtx_ff <= bvtx_in; epos_ff <= epos_in; comps_ff <= comps_in;
      var_ff <= var_in; ctrue_ff <= ctrue_in; sat_ff <= sat_in; rst_ff <= rst_in;
      rvar_ff <= rvar_in; rval_ff <= rval_in; rsat_ff <= rsat_in; rcomp_ff <= rcomp_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid = rv_ff;       assign rsp_status = rst_ff;
   assign rsp_variable = rvar_ff;  assign rsp_value = rval_ff;
   assign rsp_satisfiable = rsat_ff; assign rsp_components = rcomp_ff;
   assign rsp_last = rlast_ff;

   `ASSERT_IMPLIES(a_cnt_max, clock, reset, 1'b1, ecount_ff <= CW'(MAX_EDGES),
      "edge count above capacity")
   `ASSERT_NEXT(a_add_rsp, clock, reset, acc && req_command == CMD_ADD, rsp_valid && rsp_last,
      "add produced no result")
   `ASSERT_IMPLIES(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall,
      "item taken while solving")
endmodule

// ===== sv/tsat_ram.sv =====
// Generic single-port-write, one-read RAM with registered read
module tsat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sim/two_sat_scc_solver_top_tb.sv =====
// Testbench for the 2-SAT SCC solver: random edge loads, solves and clears, checked by a scoreboard
`timescale 1ns / 100ps

module two_sat_scc_solver_top_tb;
   import tsat_pkg::*;

   localparam int NVERT = 2 * DEF_MAX_VARS;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] variable;
      logic       value;
      logic       satisfiable;
      logic [6:0] components;
      logic       last;
   } sat_result_type;

   class sat_scoreboard;
      sat_result_type expected_q[$];
      logic [5:0]  num_vars;
      int          edge_cnt;
      int          edge_src[DEF_MAX_EDGES];
      int          edge_dst[DEF_MAX_EDGES];
      bit          seen[NVERT];
      int          finished[NVERT];
      int          comp_of[NVERT];
      int          nfin;
      int          errors;

      function new();
         num_vars = 6'd32;
         edge_cnt = 0;
         errors   = 0;
      endfunction

      function void report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endfunction

      function int vars_used();
         if (num_vars == 0) return 1;
         if (num_vars > DEF_MAX_VARS) return DEF_MAX_VARS;
         return int'(num_vars);
      endfunction

      function void dfs(int root, int nv, bit rev, int comp);
         int stk[NVERT];
         int pos[NVERT];
         int sp, v, e, a, b;
         bit pushed;
         seen[root] = 1;
         if (rev) comp_of[root] = comp;
         stk[0] = root;
         pos[0] = 0;
         sp = 1;
         while (sp > 0) begin
            v = stk[sp-1];
            e = pos[sp-1];
            pushed = 0;
            while (e < edge_cnt && !pushed) begin
               a = rev ? edge_dst[e] : edge_src[e];
               b = rev ? edge_src[e] : edge_dst[e];
               e++;
               if (a == v && a < nv && b < nv && !seen[b]) begin
                  pos[sp-1] = e;
                  seen[b] = 1;
                  if (rev) comp_of[b] = comp;
                  if (sp < NVERT) begin
                     stk[sp] = b;
                     pos[sp] = 0;
                     sp++;
                  end
                  pushed = 1;
               end
            end
            if (!pushed) begin
               pos[sp-1] = e;
               sp--;
               if (!rev && nfin < NVERT) begin
                  finished[nfin] = v;
                  nfin++;
               end
            end
         end
      endfunction

      function void note_request(logic [1:0] cmd, logic [5:0] from_v, logic [5:0] to_v);
         sat_result_type r;
         int n, nv, comps, u;
         bit sat;
         n  = vars_used();
         nv = 2 * n;
         r  = '0;
         r.last = 1'b1;
         if (cmd == CMD_ADD) begin
            if (from_v >= nv || to_v >= nv) r.status = ST_RANGE;
            else if (edge_cnt >= DEF_MAX_EDGES) r.status = ST_FULL;
            else begin
               edge_src[edge_cnt] = from_v;
               edge_dst[edge_cnt] = to_v;
               edge_cnt++;
               r.status = ST_OK;
            end
            expected_q = {expected_q, r};
         end else if (cmd == CMD_CLEAR) begin
            edge_cnt = 0;
            r.status = ST_OK;
            expected_q = {expected_q, r};
         end else if (cmd == CMD_SOLVE) begin
            nfin = 0;
            comps = 0;
            sat = 1;
            foreach (seen[i]) seen[i] = 0;
            for (int v = 0; v < nv; v++)
               if (!seen[v]) dfs(v, nv, 0, 0);
            foreach (seen[i]) seen[i] = 0;
            for (int i = nfin; i > 0; i--) begin
               u = finished[i-1];
               if (u < nv && !seen[u]) begin
                  dfs(u, nv, 1, comps);
                  comps++;
               end
            end
            for (int i = 0; i < n; i++)
               if (comp_of[i] == comp_of[n+i]) sat = 0;
            for (int i = 0; i < n; i++) begin
               r.status      = ST_OK;
               r.variable    = 5'(i);
               r.value       = comp_of[i] > comp_of[n+i];
               r.satisfiable = sat;
               r.components  = 7'(comps);
               r.last        = (i + 1 == n);
               expected_q = {expected_q, r};
            end
         end
      endfunction

      function void check_result(sat_result_type got);
         sat_result_type x;
         if (expected_q.size() == 0) begin
            report("result with nothing expected");
            return;
         end
         x = expected_q.pop_front();
         if (got.status != x.status)
            report($sformatf("status %0d exp %0d", got.status, x.status));
         if (got.variable != x.variable)
            report($sformatf("variable %0d exp %0d", got.variable, x.variable));
         if (got.value != x.value)
            report($sformatf("value %0d exp %0d (var %0d)", got.value, x.value, x.variable));
         if (got.satisfiable != x.satisfiable)
            report($sformatf("satisfiable %0d exp %0d", got.satisfiable, x.satisfiable));
         if (got.components != x.components)
            report($sformatf("components %0d exp %0d", got.components, x.components));
         if (got.last != x.last)
            report($sformatf("last %0d exp %0d", got.last, x.last));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_command;
   logic [5:0] req_from_vertex;
   logic [5:0] req_to_vertex;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic [4:0] rsp_variable;
   logic       rsp_value;
   logic       rsp_satisfiable;
   logic [6:0] rsp_components;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [5:0] csr_num_vars;

   sat_scoreboard sb;
   bit quiet;
   bit long_hold;
   int sent;

   two_sat_scc_solver_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_from_vertex(req_from_vertex), .req_to_vertex(req_to_vertex),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_variable(rsp_variable), .rsp_value(rsp_value),
      .rsp_satisfiable(rsp_satisfiable), .rsp_components(rsp_components),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_num_vars(csr_num_vars)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_request(logic [1:0] cmd, logic [5:0] from_v, logic [5:0] to_v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_from_vertex <= from_v;
      req_to_vertex   <= to_v;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
      sb.note_request(cmd, from_v, to_v);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_num_vars(logic [5:0] v);
      drain();
      csr_valid    <= 1'b1;
      csr_num_vars <= v;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      sb.num_vars = v;
   endtask

   task automatic add_random_edge(int nv);
      logic [5:0] f, t;
      if ($urandom_range(0, 9) == 0) begin
         f = 6'($urandom_range(0, 63));
         t = 6'($urandom_range(0, 63));
      end else begin
         f = 6'($urandom_range(0, nv - 1));
         t = 6'($urandom_range(0, nv - 1));
      end
      send_request(CMD_ADD, f, t);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result({rsp_status, rsp_variable, rsp_value, rsp_satisfiable,
                             rsp_components, rsp_last});
      end
   end

   initial begin
      int n, nv, edges, phase;
      logic [5:0] cfg;
      sb = new();
      quiet = 0;
      long_hold = 0;
      sent = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_ADD;
      req_from_vertex <= '0;
      req_to_vertex   <= '0;
      rsp_stall       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_num_vars    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_num_vars(6'd32);
      send_request(CMD_ADD, 6'd0, 6'd63);
      send_request(CMD_ADD, 6'd63, 6'd0);
      send_request(CMD_ADD, 6'd5, 6'd37);
      send_request(CMD_ADD, 6'd37, 6'd5);
      send_request(CMD_ADD, 6'd1, 6'd33);
      send_request(CMD_SOLVE, 6'd0, 6'd0);
      send_request(CMD_CLEAR, 6'd63, 6'd63);
      send_request(CMD_SOLVE, 6'd0, 6'd0);
      send_request(CMD_NOP, 6'd1, 6'd2);
      send_request(CMD_ADD, 6'd40, 6'd2);
      write_num_vars(6'd0);
      send_request(CMD_ADD, 6'd2, 6'd0);
      send_request(CMD_ADD, 6'd0, 6'd2);
      send_request(CMD_ADD, 6'd0, 6'd1);
      send_request(CMD_SOLVE, 6'd0, 6'd0);
      write_num_vars(6'd63);
      send_request(CMD_ADD, 6'd31, 6'd32);
      send_request(CMD_SOLVE, 6'd0, 6'd0);
      write_num_vars(6'd1);
      send_request(CMD_ADD, 6'd1, 6'd0);
      send_request(CMD_SOLVE, 6'd0, 6'd0);

      phase = 0;
      while (sent < 420) begin
         if (sent > 360) quiet = 1;
         case ($urandom_range(0, 7))
            0:       cfg = 6'd0;
            1:       cfg = 6'd63;
            2:       cfg = 6'd32;
            3:       cfg = 6'($urandom_range(17, 32));
            default: cfg = 6'($urandom_range(1, 8));
         endcase
         if (phase == 2) cfg = 6'd1;
         write_num_vars(cfg);
         n  = sb.vars_used();
         nv = 2 * n;
         if (phase == 2) begin
            send_request(CMD_CLEAR, 6'd0, 6'd0);
            for (int i = 0; i < DEF_MAX_EDGES + 2; i++)
               send_request(CMD_ADD, 6'($urandom_range(0, nv - 1)),
                            6'($urandom_range(0, nv - 1)));
            send_request(CMD_SOLVE, 6'd0, 6'd0);
            send_request(CMD_CLEAR, 6'd0, 6'd0);
         end else begin
            if (sb.edge_cnt > 48 || $urandom_range(0, 2) != 0)
               send_request(CMD_CLEAR, 6'($urandom), 6'($urandom));
            edges = (n > 8) ? $urandom_range(1, 40) : $urandom_range(0, 20);
            for (int i = 0; i < edges; i++) begin
               if (phase == 1 && i == 1) long_hold = 1;
               add_random_edge(nv);
            end
            if ($urandom_range(0, 4) == 0)
               send_request(CMD_NOP, 6'($urandom), 6'($urandom));
            send_request(CMD_SOLVE, 6'($urandom), 6'($urandom));
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
